[rtl/cbq_pkg.sv]
package cbq_pkg;

    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 12;
    localparam int LENGTH_W   = 16;
    localparam int RES_W      = 13;
    localparam int LIMIT_W    = 5;
    localparam int BUDGET_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_LIMIT = 1'd1;

    localparam logic [LIMIT_W-1:0]  CHUNK_LIMIT_RST  = 5'd16;
    localparam logic [BUDGET_W-1:0] BUDGET_LIMIT_RST = 16'd4608;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BYTE_W-1:0]   data_byte;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } t_in_item;

    typedef struct packed {
        logic                accepted;
        logic [BYTE_W-1:0]   read_byte;
        logic [RES_W-1:0]    removed_count;
        logic [RES_W-1:0]    stored_bytes;
        logic [RES_W-1:0]    free_bytes;
        logic [RES_W-1:0]    budget_used;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic drain;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic drain_busy;
    } t_status;

endpackage

[rtl/cbq_in_if.sv]
interface cbq_in_if;
    import cbq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/cbq_out_if.sv]
interface cbq_out_if;
    import cbq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/cbq_ctrl.sv]
module cbq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cbq_pkg::t_cmd   o_cmd,
    input  cbq_pkg::t_status i_status
);
    import cbq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                n_state     = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_status.drain_busy) begin
                    cmd.drain = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

[rtl/cbq_datapath.sv]
module cbq_datapath #(
    parameter int CHUNK_BYTES = 256,
    parameter int CHUNK_COST  = 288,
    parameter int MAX_CHUNKS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbq_pkg::t_cmd                       i_cmd,
    output cbq_pkg::t_status                    o_status,
    input  cbq_pkg::t_in_item                   i_item,
    output cbq_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cbq_pkg::*;

    localparam int DEPTH = MAX_CHUNKS * CHUNK_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int AW1   = AW + 1;
    localparam int SW    = $clog2(DEPTH + 1);
    localparam int SW1   = SW + 1;
    localparam int HW    = $clog2(MAX_CHUNKS + 1);
    localparam int CW    = $clog2(MAX_CHUNKS * CHUNK_COST + 1);
    localparam int PW    = ((AW > OFFSET_W) ? AW : OFFSET_W) + 2;
    localparam int LW    = (SW > LENGTH_W) ? SW : LENGTH_W;
    localparam int BW    = ((CW > BUDGET_W) ? CW : BUDGET_W) + 1;
    localparam int MW    = (HW > LIMIT_W) ? HW : LIMIT_W;

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [MODE_W-1:0]   r_mode;
    logic [BYTE_W-1:0]   r_data;
    logic [OFFSET_W-1:0] r_offset;
    logic [LENGTH_W-1:0] r_length;

    logic [LIMIT_W-1:0]  r_chunk_limit;
    logic [BUDGET_W-1:0] r_budget_limit;

    logic [AW-1:0] r_base,     n_base;
    logic [HW-1:0] r_held,     n_held;
    logic [SW-1:0] r_head_off, n_head_off;
    logic [SW-1:0] r_size,     n_size;
    logic [SW-1:0] r_total,    n_total;
    logic [CW-1:0] r_cost,     n_cost;

    logic          r_res_acc;
    logic          r_res_rd_ok;
    logic [SW-1:0] r_res_removed;
    logic [BYTE_W-1:0] r_rd_data;
    t_out_item     r_out;

    logic [SW-1:0] used;
    logic          tail_full;
    logic [HW-1:0] lim;
    logic [SW-1:0] lim_bytes;
    logic          held_ok;
    logic [BW-1:0] cost_grow;
    logic          app_ok;
    logic [PW-1:0] pos;
    logic [PW-1:0] sum;
    logic [PW-1:0] addr_wide;
    logic [AW-1:0] addr;
    logic          rd_ok;
    logic [SW-1:0] removed;
    logic [SW-1:0] size_after;
    logic [SW-1:0] hoff_after;
    logic          drain_busy;
    logic [AW1-1:0] base_sum;
    logic [AW-1:0] base_adv;
    logic [SW-1:0] free_bytes;
    logic          mem_we;

    assign used      = r_head_off + r_size;
    assign tail_full = (used == r_total);

    // clip the chunk limit to the slot count
    assign lim = (MW'(r_chunk_limit) >= MW'(MAX_CHUNKS)) ? HW'(MAX_CHUNKS)
                                                         : HW'(r_chunk_limit);
    assign lim_bytes = SW'(lim * CHUNK_BYTES);
    assign held_ok   = (r_held < lim);
    assign cost_grow = BW'(r_cost) + BW'(CHUNK_COST);
    assign app_ok    = !tail_full || (held_ok && (cost_grow <= BW'(r_budget_limit)));

    // ring address: (head slot base + position) modulo store depth
    assign pos = PW'(r_head_off) +
                 ((r_mode == MODE_READ) ? PW'(r_offset) : PW'(r_size));
    assign sum = PW'(r_base) + pos;
    assign addr_wide = (sum >= PW'(DEPTH)) ? (sum - PW'(DEPTH)) : sum;
    assign addr      = addr_wide[AW-1:0];
    assign rd_ok     = (PW'(r_offset) < PW'(r_size));

    assign removed    = (LW'(r_length) < LW'(r_size)) ? SW'(r_length) : r_size;
    assign size_after = r_size - removed;
    assign hoff_after = r_head_off + removed;

    assign drain_busy = (r_head_off >= SW'(CHUNK_BYTES)) && (r_held != '0);
    assign base_sum   = AW1'(r_base) + AW1'(CHUNK_BYTES);
    assign base_adv   = (base_sum >= AW1'(DEPTH)) ? '0 : base_sum[AW-1:0];

    assign free_bytes = held_ok ? (lim_bytes - used) : (r_total - used);

    assign mem_we = i_cmd.execute && (r_mode == MODE_APPEND) && app_ok;

    always_comb begin
        n_base     = r_base;
        n_held     = r_held;
        n_head_off = r_head_off;
        n_size     = r_size;
        n_total    = r_total;
        n_cost     = r_cost;
        if (i_cmd.execute) begin
            unique case (r_mode)
                MODE_APPEND: begin
                    if (app_ok) begin
                        if (tail_full) begin
                            n_held  = r_held + 1'b1;
                            n_total = r_total + SW'(CHUNK_BYTES);
                            n_cost  = r_cost + CW'(CHUNK_COST);
                        end
                        n_size = r_size + 1'b1;
                    end
                end
                MODE_READ: begin
                end
                MODE_CONSUME: begin
                    if (size_after == '0) begin
                        n_base     = '0;
                        n_held     = '0;
                        n_head_off = '0;
                        n_size     = '0;
                        n_total    = '0;
                        n_cost     = '0;
                    end else begin
                        n_size     = size_after;
                        n_head_off = hoff_after;
                    end
                end
                MODE_CLEAR: begin
                    n_base     = '0;
                    n_held     = '0;
                    n_head_off = '0;
                    n_size     = '0;
                    n_total    = '0;
                    n_cost     = '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.drain && drain_busy) begin
            // free one drained chunk at the head
            n_base     = base_adv;
            n_held     = r_held - 1'b1;
            n_head_off = r_head_off - SW'(CHUNK_BYTES);
            n_total    = r_total - SW'(CHUNK_BYTES);
            n_cost     = r_cost - CW'(CHUNK_COST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base         <= '0;
            r_held         <= '0;
            r_head_off     <= '0;
            r_size         <= '0;
            r_total        <= '0;
            r_cost         <= '0;
            r_chunk_limit  <= CHUNK_LIMIT_RST;
            r_budget_limit <= BUDGET_LIMIT_RST;
        end else begin
            r_base     <= n_base;
            r_held     <= n_held;
            r_head_off <= n_head_off;
            r_size     <= n_size;
            r_total    <= n_total;
            r_cost     <= n_cost;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CHUNK_LIMIT:  r_chunk_limit  <= i_cfg_data[LIMIT_W-1:0];
                    CFG_BUDGET_LIMIT: r_budget_limit <= i_cfg_data[BUDGET_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_item.mode;
            r_data   <= i_item.data_byte;
            r_offset <= i_item.offset;
            r_length <= i_item.length;
        end
        if (i_cmd.execute) begin
            r_res_acc   <= ((r_mode == MODE_APPEND) && app_ok) ||
                           ((r_mode == MODE_READ) && rd_ok);
            r_res_rd_ok <= (r_mode == MODE_READ) && rd_ok;
            if (r_mode == MODE_CONSUME) begin
                r_res_removed <= removed;
            end else if (r_mode == MODE_CLEAR) begin
                r_res_removed <= r_size;
            end else begin
                r_res_removed <= '0;
            end
        end
        if (i_cmd.load_out) begin
            r_out.accepted      <= r_res_acc;
            r_out.read_byte     <= r_res_rd_ok ? r_rd_data : '0;
            r_out.removed_count <= RES_W'(r_res_removed);
            r_out.stored_bytes  <= RES_W'(r_size);
            r_out.free_bytes    <= RES_W'(free_bytes);
            r_out.budget_used   <= RES_W'(r_cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= r_data;
        end
        if (i_cmd.execute) begin
            r_rd_data <= mem[addr];
        end
    end

    assign o_status.drain_busy = drain_busy;
    assign o_item              = r_out;

`ifndef SYNTHESIS
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(MAX_CHUNKS))
        else $error("chunk count above slot count");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW1'(r_head_off) + SW1'(r_size)) <= SW1'(r_total))
        else $error("bytes held exceed chunk capacity");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == '0) |-> ((r_size == '0) && (r_total == '0) && (r_cost == '0)))
        else $error("no chunk held but queue not empty");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && tail_full) |=> (r_held == HW'($past(r_held) + 1'b1)))
        else $error("append into full tail did not take a chunk");
`endif
endmodule

[rtl/chunked_byte_queue.sv]
// Chunked byte queue: a byte FIFO stored in a ring of MAX_CHUNKS chunk slots
// of CHUNK_BYTES each, held in one single-port byte memory. Each request
// carries a mode: append one byte (a fresh chunk is taken when the tail chunk
// is full, if the chunk limit and the byte budget allow it), read the byte at
// an offset from the head, consume up to a length of bytes from the head, or
// clear. Every request returns exactly one response with the accepted flag,
// the byte read, the bytes removed, and the stored size, free space and
// budget used after the request. Requests are handled one at a time: a
// request passes capture, execute with the memory access, a drain of each
// whole chunk that a consume frees at the head (the drain sequencer retires
// one chunk per cycle), and the load of the response register. The response
// register lets the next request be taken while the previous response still
// waits downstream. chunk_limit (index 0) and budget_limit (index 1) are to
// be written through the configuration port only while the queue is idle;
// the block does not enforce this. They reset to 16 chunks and 4608 bytes.
// The byte memory has no reset; only appended bytes are ever returned.
module chunked_byte_queue #(
    parameter int CHUNK_BYTES = 256,
    parameter int CHUNK_COST  = 288,
    parameter int MAX_CHUNKS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbq_in_if.sink                          i_in,
    cbq_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cbq_pkg::*;

    t_cmd      cmd;
    t_status   status;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // sequence each request: capture, execute, drain freed chunks, respond
    cbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // queue state, byte memory, configuration and response register
    cbq_datapath #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .CHUNK_COST  (CHUNK_COST),
        .MAX_CHUNKS  (MAX_CHUNKS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_item     (i_in.data),
        .o_item     (out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;
endmodule
